// ===== sv/salc_pkg.sv =====
// shared sizes, types and helpers for the set-associative lru cache lookup
`timescale 1ns / 1ps

package salc_pkg;

   // cache geometry
   localparam int SETS      = 64;
   localparam int WAYS      = 4;
   localparam int ADDR_BITS = 32;

   // floor(log2(SETS)) bits are shifted off to form the tag
   localparam int IDX_BITS = $clog2(SETS + 1) - 1;
   // bits needed to hold a set number below SETS
   localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int TAG_W    = ADDR_BITS - IDX_BITS;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W   = WAY_W;
   localparam int WAY_OUT_W = 2;

   localparam logic [ADDR_BITS-1:0] SET_MASK = ADDR_BITS'(SETS - 1);

   // one memory row holds the tags and age ranks of every way of a set
   typedef struct packed {
      logic [WAYS-1:0][TAG_W-1:0]  tags;
      logic [WAYS-1:0][RANK_W-1:0] ranks;
   } row_type;

   // outcome of one lookup, handed from the way logic to the control
   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic [WAYS-1:0]  valid;
      row_type          row;
   } decision_type;

endpackage

// ===== sv/salc_set_ram.sv =====
// synchronous single-read single-write memory of set rows
`timescale 1ns / 1ps

module salc_set_ram
   import salc_pkg::*;
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic [SET_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [SET_W-1:0] wr_addr,
   input  row_type          wr_data,
   output row_type          rd_data
);

   row_type row_mem_ff [SETS];
   row_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/salc_way_logic.sv =====
// tag compare, way choice and lru rank update for one set
`timescale 1ns / 1ps

module salc_way_logic
   import salc_pkg::*;
(
   input  row_type          row,
   input  logic [WAYS-1:0]  valid,
   input  logic [TAG_W-1:0] tag,
   output decision_type     decision
);

   logic [WAYS-1:0]   match;
   logic              hit;
   logic [WAY_W-1:0]  hit_way;
   logic              has_free;
   logic [WAY_W-1:0]  free_way;
   logic [WAY_W-1:0]  victim;
   logic [RANK_W-1:0] best;
   logic [WAY_W-1:0]  way;
   logic [RANK_W:0]   old_rank;
   row_type           new_row;
   logic [WAYS-1:0]   new_valid;

   // tag compare against valid ways
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w] = valid[w] && (row.tags[w] == tag);
      end
   end

   // lowest matching way, lowest invalid way, oldest way
   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      has_free = 1'b0;
      free_way = '0;
      victim   = '0;
      best     = row.ranks[0];
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!valid[w]) begin
            has_free = 1'b1;
            free_way = WAY_W'(w);
         end
      end
      for (int w = 1; w < WAYS; w++) begin
         if (row.ranks[w] > best) begin
            best   = row.ranks[w];
            victim = WAY_W'(w);
         end
      end
   end

   // way to touch and the rank it had before
   always_comb begin
      if (hit) begin
         way      = hit_way;
         old_rank = {1'b0, row.ranks[hit_way]};
      end else if (has_free) begin
         way      = free_way;
         old_rank = (RANK_W + 1)'(WAYS);
      end else begin
         way      = victim;
         old_rank = {1'b0, row.ranks[victim]};
      end
   end

   // age the more recent valid ways, touched way becomes most recent
   always_comb begin
      new_row   = row;
      new_valid = valid;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == way) begin
            new_row.ranks[w] = '0;
            new_valid[w]     = 1'b1;
            if (!hit) begin
               new_row.tags[w] = tag;
            end
         end else if (valid[w] && ({1'b0, row.ranks[w]} < old_rank)) begin
            new_row.ranks[w] = row.ranks[w] + RANK_W'(1);
         end
      end
   end

   assign decision.hit   = hit;
   assign decision.way   = way;
   assign decision.valid = new_valid;
   assign decision.row   = new_row;

endmodule

// ===== sv/set_assoc_lru_cache_lookup_unit.sv =====
// top level of the set-associative cache lookup with lru replacement
// the set row is read when the item is accepted, then updated and the result registered
// a new item is taken only after the last one has written back its set row (read-then-write);
// a result still waiting for rsp_ready holds the update and the next item
// the row memory port carries one read and one write per item
// reset clears all valid bits at once; no clearing pass, items taken right after reset
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup_unit
   import salc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ADDR_BITS-1:0] req_address,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_hit,
   output logic [WAY_OUT_W-1:0] rsp_way_used
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic                 state_ff, state_in;
   logic [SET_W-1:0]     set_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [WAYS-1:0]      valid_ff [SETS];
   logic                 out_valid_ff, out_valid_in;
   logic                 hit_ff;
   logic [WAY_OUT_W-1:0] way_ff;

   logic                 accept;
   logic                 finish;
   logic [SET_W-1:0]     req_set;
   row_type              rd_row;
   decision_type         decision;

   // request split into set and tag
   assign req_set   = SET_W'(req_address & SET_MASK);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // lookup completes once the output register is free
   assign finish    = (state_ff == ST_LOOKUP) && (!out_valid_ff || rsp_ready);

   salc_set_ram u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_set),
      .wr_en   (finish),
      .wr_addr (set_ff),
      .wr_data (decision.row),
      .rd_data (rd_row)
   );

   salc_way_logic u_way (
      .row      (rd_row),
      .valid    (valid_ff[set_ff]),
      .tag      (tag_ff),
      .decision (decision)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output handshake
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (finish)    out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // captured item
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= req_set;
         tag_ff <= TAG_W'(req_address >> IDX_BITS);
      end
   end

   // valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else if (finish) begin
         valid_ff[set_ff] <= decision.valid;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (finish) begin
         hit_ff <= decision.hit;
         way_ff <= WAY_OUT_W'({{WAY_OUT_W{1'b0}}, decision.way});
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_hit      = hit_ff;
   assign rsp_way_used = way_ff;

endmodule
